/* rtl/rars_pkg.sv */
// Package for the range-add / range-sum tree: field widths, command codes,
// register map and the walker state type. Used by every file of the block.
package rars_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam int unsigned SIZE_RESET       = 1024;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SUM_W  = 64;
  localparam int unsigned WORD_W = 2 * SUM_W;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [CMD_W-1:0] CMD_SUM   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Word index of a register, taken from paddr[2].
  localparam logic REG_ARRAY_SIZE = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_UPDATE,
    ST_DONE
  } walk_state_e;

endpackage

/* rtl/rars_if.sv */
// Valid/ready channel interfaces for command items and result items.
// Depends on rars_pkg for the field widths.
interface rars_in_if;
  logic                              valid;
  logic                              ready;
  logic [rars_pkg::CMD_W-1:0]        command;
  logic [rars_pkg::POS_W-1:0]        range_start;
  logic [rars_pkg::POS_W-1:0]        range_end;
  logic signed [rars_pkg::VAL_W-1:0] add_value;
  modport source(output valid, command, range_start, range_end, add_value, input ready);
  modport sink(input valid, command, range_start, range_end, add_value, output ready);
endinterface

interface rars_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rars_pkg::SUM_W-1:0] range_sum;
  modport source(output valid, range_sum, input ready);
  modport sink(input valid, range_sum, output ready);
endinterface

/* rtl/rars_cfg.sv */
// APB-style register file holding the array_size register.
// Depends on rars_pkg; pulses clear_o on every write of the register.
module rars_cfg #(
  parameter int unsigned MAX_ELEMENTS = rars_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rars_pkg::APB_AW-1:0]   paddr,
  input  logic [rars_pkg::APB_DW-1:0]   pwdata,
  output logic [rars_pkg::APB_DW-1:0]   prdata,
  output logic [$clog2(MAX_ELEMENTS+1)-1:0] size_o,
  output logic                          clear_o
);
  localparam int unsigned PW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CW = (rars_pkg::POS_W > PW) ? rars_pkg::POS_W : PW;
  localparam int unsigned RST_SIZE =
    (rars_pkg::SIZE_RESET > MAX_ELEMENTS) ? MAX_ELEMENTS : rars_pkg::SIZE_RESET;

  logic [PW-1:0] size_q, size_d;
  logic [CW-1:0] raw_ext;
  logic          wr_hit;

  assign wr_hit  = psel && penable && pwrite && (paddr[2] == rars_pkg::REG_ARRAY_SIZE);
  assign raw_ext = CW'(pwdata[rars_pkg::POS_W-1:0]);

  always_comb begin
    size_d = size_q;
    if (wr_hit) begin
      if (raw_ext == '0) begin
        size_d = PW'(1);
      end else if (raw_ext > CW'(MAX_ELEMENTS)) begin
        size_d = PW'(MAX_ELEMENTS);
      end else begin
        size_d = PW'(raw_ext);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= PW'(RST_SIZE);
    end else begin
      size_q <= size_d;
    end
  end

  assign prdata  = (paddr[2] == rars_pkg::REG_ARRAY_SIZE) ?
                   rars_pkg::APB_DW'(size_q) : '0;
  assign size_o  = size_q;
  assign clear_o = wr_hit;
endmodule

/* rtl/rars_mem.sv */
// Tree node store: one write port, one read port with registered read data.
// Each word holds {pending mark, node sum}; depends on rars_pkg for the width.
module rars_mem #(
  parameter int unsigned DEPTH = 4 * rars_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [AW-1:0]                 rd_addr_i,
  output logic [rars_pkg::WORD_W-1:0]   rd_data_o,
  input  logic                          wr_en_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic [rars_pkg::WORD_W-1:0]   wr_data_i
);
  logic [rars_pkg::WORD_W-1:0] mem [DEPTH];
  logic [rars_pkg::WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule

/* rtl/rars_walk.sv */
// Tree walker: takes command items, walks the node store depth first with a
// small stack, and drives the result register. Depends on rars_pkg, rars_if.
module rars_walk #(
  parameter int unsigned MAX_ELEMENTS = rars_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  rars_in_if.sink                             in_i,
  rars_out_if.source                          out_o,
  input  logic [$clog2(MAX_ELEMENTS+1)-1:0]   size_i,
  input  logic                                clear_i,
  output logic                                rd_en_o,
  output logic [$clog2(4*MAX_ELEMENTS)-1:0]   rd_addr_o,
  input  logic [rars_pkg::WORD_W-1:0]         rd_data_i,
  output logic                                wr_en_o,
  output logic [$clog2(4*MAX_ELEMENTS)-1:0]   wr_addr_o,
  output logic [rars_pkg::WORD_W-1:0]         wr_data_o
);
  localparam int unsigned PW    = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CW    = (rars_pkg::POS_W > PW) ? rars_pkg::POS_W : PW;
  localparam int unsigned DEPTH = 4 * MAX_ELEMENTS;
  localparam int unsigned NW    = $clog2(DEPTH);
  localparam int unsigned SD    = $clog2(MAX_ELEMENTS) + 2;
  localparam int unsigned SIW   = $clog2(SD);
  localparam int unsigned SPW   = $clog2(SD + 1);
  localparam int unsigned SW    = rars_pkg::SUM_W;

  rars_pkg::walk_state_e state_q, state_d;
  logic [NW-1:0]  clr_q, clr_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic           out_valid_q, out_valid_d;

  logic [rars_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic [PW-1:0]  a_q, a_d, b_q, b_d, lo_q, lo_d, hi_q, hi_d;
  logic [NW-1:0]  node_q, node_d;
  logic [SW-1:0]  v_q, v_d, acc_q, acc_d, prod_q, prod_d, out_sum_q, out_sum_d;

  logic [NW-1:0]  stk_node [SD];
  logic [PW-1:0]  stk_lo   [SD];
  logic [PW-1:0]  stk_hi   [SD];
  logic           push;
  logic [SIW-1:0] top_idx;

  logic [CW-1:0]  a_ext, b_ext, n_ext, a_cl, b_cl;
  logic           empty;
  logic [SW-1:0]  node_sum, node_tag;
  logic [PW-1:0]  mid, lo_m, hi_m, ovl;
  logic           full, go_left, go_right;

  assign a_ext = CW'(in_i.range_start);
  assign b_ext = CW'(in_i.range_end);
  assign n_ext = CW'(size_i);
  assign a_cl  = (a_ext == '0) ? CW'(1) : a_ext;
  assign b_cl  = (b_ext > n_ext) ? n_ext : b_ext;
  assign empty = a_cl > b_cl;

  assign node_sum = rd_data_i[SW-1:0];
  assign node_tag = rd_data_i[2*SW-1:SW];
  assign mid      = PW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  assign lo_m     = (lo_q > a_q) ? lo_q : a_q;
  assign hi_m     = (hi_q < b_q) ? hi_q : b_q;
  assign ovl      = hi_m - lo_m + PW'(1);
  assign full     = (lo_q >= a_q) && (hi_q <= b_q);
  assign go_left  = a_q <= mid;
  assign go_right = b_q > mid;

  logic [SPW-1:0] sp_m1;
  assign sp_m1   = sp_q - SPW'(1);
  assign top_idx = sp_m1[SIW-1:0];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    sp_d        = sp_q;
    out_valid_d = out_valid_q;
    cmd_d       = cmd_q;
    a_d         = a_q;
    b_d         = b_q;
    v_d         = v_q;
    acc_d       = acc_q;
    node_d      = node_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    prod_d      = prod_q;
    out_sum_d   = out_sum_q;
    rd_en_o     = 1'b0;
    wr_en_o     = 1'b0;
    wr_addr_o   = node_q;
    wr_data_o   = '0;
    push        = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      rars_pkg::ST_CLEAR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = clr_q;
        clr_d     = clr_q + NW'(1);
        if (clr_q == NW'(DEPTH - 1)) begin
          state_d = rars_pkg::ST_IDLE;
        end
      end
      rars_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d  = in_i.command;
          a_d    = PW'(a_cl);
          b_d    = PW'(b_cl);
          v_d    = {{(SW - rars_pkg::VAL_W){in_i.add_value[rars_pkg::VAL_W-1]}},
                    in_i.add_value};
          acc_d  = '0;
          node_d = NW'(1);
          lo_d   = PW'(1);
          hi_d   = size_i;
          sp_d   = '0;
          case (in_i.command)
            rars_pkg::CMD_SUM:   state_d = empty ? rars_pkg::ST_DONE : rars_pkg::ST_READ;
            rars_pkg::CMD_ADD:   state_d = empty ? rars_pkg::ST_IDLE : rars_pkg::ST_READ;
            rars_pkg::CMD_CLEAR: begin
              clr_d   = '0;
              state_d = rars_pkg::ST_CLEAR;
            end
            default: state_d = rars_pkg::ST_IDLE;
          endcase
        end
      end
      rars_pkg::ST_READ: begin
        rd_en_o = 1'b1;
        state_d = rars_pkg::ST_WAIT;
      end
      rars_pkg::ST_WAIT: begin
        // Marks stay at their node: a partly covered node adds mark*overlap to a sum; an add adds value*overlap.
        prod_d  = ((cmd_q == rars_pkg::CMD_ADD) ? v_q : node_tag) * SW'(ovl);
        state_d = rars_pkg::ST_UPDATE;
      end
      rars_pkg::ST_UPDATE: begin
        if (cmd_q == rars_pkg::CMD_ADD) begin
          wr_en_o   = 1'b1;
          wr_data_o = {node_tag + (full ? v_q : '0), node_sum + prod_q};
        end else begin
          acc_d = acc_q + (full ? node_sum : prod_q);
        end
        if (!full && go_left) begin
          node_d  = NW'({node_q, 1'b0});
          hi_d    = mid;
          push    = go_right;
          if (go_right) begin
            sp_d = sp_q + SPW'(1);
          end
          state_d = rars_pkg::ST_READ;
        end else if (!full && go_right) begin
          node_d  = NW'({node_q, 1'b1});
          lo_d    = mid + PW'(1);
          state_d = rars_pkg::ST_READ;
        end else if (sp_q != '0) begin
          node_d  = stk_node[top_idx];
          lo_d    = stk_lo[top_idx];
          hi_d    = stk_hi[top_idx];
          sp_d    = sp_m1;
          state_d = rars_pkg::ST_READ;
        end else begin
          state_d = (cmd_q == rars_pkg::CMD_SUM) ? rars_pkg::ST_DONE : rars_pkg::ST_IDLE;
        end
      end
      rars_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_sum_d   = acc_q;
          state_d     = rars_pkg::ST_IDLE;
        end
      end
      default: state_d = rars_pkg::ST_IDLE;
    endcase

    // A size write restarts the clearing pass.
    if (clear_i) begin
      state_d = rars_pkg::ST_CLEAR;
      clr_d   = '0;
    end
  end

  assign rd_addr_o = node_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rars_pkg::ST_CLEAR;
      clr_q       <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    a_q       <= a_d;
    b_q       <= b_d;
    v_q       <= v_d;
    acc_q     <= acc_d;
    node_q    <= node_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    prod_q    <= prod_d;
    out_sum_q <= out_sum_d;
    if (push) begin
      stk_node[sp_q[SIW-1:0]] <= NW'({node_q, 1'b1});
      stk_lo[sp_q[SIW-1:0]]   <= mid + PW'(1);
      stk_hi[sp_q[SIW-1:0]]   <= hi_q;
    end
  end

  assign in_i.ready      = (state_q == rars_pkg::ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.range_sum = out_sum_q;
endmodule

/* rtl/range_add_range_sum_tree.sv */
// Range-add / range-sum store over positions 1..array_size, kept as a tree of
// node sums and add marks in one synchronous memory of 4*MAX_ELEMENTS words.
// Every visited node goes through three steps (memory read, multiply, write
// back or accumulate), and an item visits up to 4 nodes per tree level. An
// empty range sum still returns a zero result and an empty range add is taken
// with no node visit. A clear command, a write of array_size and reset start a
// clearing pass over all 4*MAX_ELEMENTS words during which no item is taken.
// One item is in work at a time; a finished sum waits in the output register
// while the next item is accepted. Depends on rars_pkg, rars_if, rars_cfg,
// rars_mem and rars_walk.
module range_add_range_sum_tree #(
  parameter int unsigned MAX_ELEMENTS = rars_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rars_in_if.sink                     in_i,
  rars_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rars_pkg::APB_AW-1:0] paddr,
  input  logic [rars_pkg::APB_DW-1:0] pwdata,
  output logic [rars_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  localparam int unsigned PW    = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned DEPTH = 4 * MAX_ELEMENTS;
  localparam int unsigned NW    = $clog2(DEPTH);

  logic [PW-1:0]               size;
  logic                        clear;
  logic                        rd_en, wr_en;
  logic [NW-1:0]               rd_addr, wr_addr;
  logic [rars_pkg::WORD_W-1:0] rd_data, wr_data;

  assign pready = 1'b1;

  rars_cfg #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .size_o(size), .clear_o(clear)
  );

  rars_mem #(.DEPTH(DEPTH), .AW(NW)) u_mem (
    .clk_i,
    .rd_en_i(rd_en), .rd_addr_i(rd_addr), .rd_data_o(rd_data),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data)
  );

  rars_walk #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_walk (
    .clk_i, .rst_ni, .in_i, .out_o,
    .size_i(size), .clear_i(clear),
    .rd_en_o(rd_en), .rd_addr_o(rd_addr), .rd_data_i(rd_data),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data)
  );
endmodule

/* rtl/rars_chk.sv */
// Port-level checker for range_add_range_sum_tree, bound to the top level.
// Depends on rars_pkg for the result width and the register index.
module rars_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [rars_pkg::SUM_W-1:0] out_sum_i,
  input logic                       psel_i,
  input logic                       penable_i,
  input logic                       pwrite_i,
  input logic                       paddr2_i,
  input logic                       pready_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_sum_i))
    else $error("stalled result item changed");

  // A size write starts the clearing pass, so no item is taken right after.
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i && pready_i && (paddr2_i == rars_pkg::REG_ARRAY_SIZE)
    |=> !in_ready_i)
    else $error("input taken right after a size write");

  // A result only appears at the end of a query, while the input side is busy.
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result item appeared while idle");
endmodule

bind range_add_range_sum_tree rars_chk u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_i.valid), .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready), .out_sum_i(out_o.range_sum),
  .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr2_i(paddr[2]),
  .pready_i(pready)
);
